FILE: sv/triac_phase_soft_start_unit_defines.svh
// Assertion macros shared by the soft-start RTL.
`ifndef TRIAC_PHASE_SOFT_START_UNIT_DEFINES_SVH
`define TRIAC_PHASE_SOFT_START_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define TPSS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define TPSS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: sv/tpss_pkg.sv
// Types, codes and reset constants of the triac soft-start unit.
`timescale 1ns / 1ps
`default_nettype none

package tpss_pkg;

	localparam int unsigned DW = 8;

	localparam logic [DW-1:0] START_DELAY_RST      = 8'd70;
	localparam logic [DW-1:0] END_DELAY_RST        = 8'd30;
	localparam logic [DW-1:0] FIRINGS_PER_STEP_RST = 8'd1;
	localparam logic [DW-1:0] CNT_MAX              = 8'hff;

	// Item kind
	typedef enum logic {
		KIND_CMD  = 1'b0,
		KIND_TICK = 1'b1
	} kind_t;

	// Command modes; the fourth code is unused
	typedef enum logic [1:0] {
		MODE_OFF  = 2'd0,
		MODE_FULL = 2'd1,
		MODE_SOFT = 2'd2
	} mode_t;

	// Configuration register indexes
	typedef enum logic [1:0] {
		REG_START_DELAY      = 2'd0,
		REG_END_DELAY        = 2'd1,
		REG_FIRINGS_PER_STEP = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [DW-1:0] start_delay;
		logic [DW-1:0] end_delay;
		logic [DW-1:0] firings_per_step;
	} cfg_t;

	typedef struct packed {
		logic          kind;
		logic [1:0]    mode;
		logic          zero_cross;
	} item_t;

	typedef struct packed {
		logic          gate_level;
		logic          done_flag;
		logic          armed_flag;
		logic          crossing_on;
		logic [DW-1:0] phase_count;
		logic [DW-1:0] firing_delay;
		logic [DW-1:0] firing_count;
	} st_t;

	localparam st_t ST_RESET = '{
		gate_level:   1'b0,
		done_flag:    1'b1,
		armed_flag:   1'b0,
		crossing_on:  1'b0,
		phase_count:  '0,
		firing_delay: START_DELAY_RST,
		firing_count: '0
	};

endpackage

`default_nettype wire

FILE: sv/tpss_ifs.sv
// Channel interfaces: command/tick items, results and configuration writes.
`timescale 1ns / 1ps
`default_nettype none

interface tpss_item_if;
	logic       valid;
	logic       ready;
	logic       kind;
	logic [1:0] mode;
	logic       zero_cross;

	modport source (output valid, kind, mode, zero_cross, input ready);
	modport sink   (input valid, kind, mode, zero_cross, output ready);
endinterface

interface tpss_result_if;
	logic valid;
	logic ready;
	logic gate_on;
	logic start_done;
	logic crossing_enable;

	modport source (output valid, gate_on, start_done, crossing_enable, input ready);
	modport sink   (input valid, gate_on, start_done, crossing_enable, output ready);
endinterface

interface tpss_cfg_if;
	logic       valid;
	logic       ready;
	logic [1:0] index;
	logic [7:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: sv/tpss_step.sv
// Next-state logic for one command or tick beat.
`timescale 1ns / 1ps
`default_nettype none

module tpss_step
	import tpss_pkg::*;
(
	input  st_t   st,
	input  cfg_t  cfg,
	input  item_t itm,
	output st_t   nxt
);

	logic [DW-1:0] pc_start;
	logic [DW-1:0] pc_inc;
	logic [DW-1:0] fc_inc;
	logic [DW-1:0] fd_dec;
	logic          fire;
	logic          step_done;

	// Phase counter: restart on crossing, then count up saturating
	assign pc_start = itm.zero_cross ? DW'(1) : st.phase_count;
	assign pc_inc   = (pc_start != CNT_MAX) ? pc_start + DW'(1) : pc_start;
	assign fire     = (pc_start != '0) && (pc_inc == st.firing_delay);

	// Firing count and delay step
	assign fc_inc    = (st.firing_count != CNT_MAX) ? st.firing_count + DW'(1)
	                                                : st.firing_count;
	assign step_done = (fc_inc == cfg.firings_per_step);
	assign fd_dec    = (st.firing_delay != '0) ? st.firing_delay - DW'(1) : '0;

	always_comb begin
		nxt = st;
		unique case (kind_t'(itm.kind))
			KIND_CMD: begin
				unique case (itm.mode)
					MODE_OFF, MODE_FULL: begin
						nxt.gate_level  = (itm.mode == MODE_FULL);
						nxt.armed_flag  = 1'b0;
						nxt.done_flag   = 1'b1;
						nxt.crossing_on = 1'b0;
					end
					MODE_SOFT: begin
						if (!st.armed_flag) begin
							nxt.done_flag  = 1'b0;
							nxt.armed_flag = 1'b1;
						end else if (st.done_flag) begin
							nxt.gate_level = 1'b1;
						end
					end
					default: ;
				endcase
			end
			KIND_TICK: begin
				if (st.done_flag) begin
					nxt.phase_count  = '0;
					nxt.firing_count = '0;
					nxt.firing_delay = cfg.start_delay;
				end else begin
					nxt.crossing_on = 1'b1;
					if (st.phase_count == '0)
						nxt.gate_level = 1'b0;
					nxt.phase_count = (pc_start != '0) ? pc_inc : pc_start;
					if (fire) begin
						nxt.gate_level   = 1'b1;
						nxt.phase_count  = '0;
						nxt.firing_count = fc_inc;
						if (step_done) begin
							nxt.firing_count = '0;
							nxt.firing_delay = fd_dec;
							if (fd_dec <= cfg.end_delay) begin
								nxt.done_flag   = 1'b1;
								nxt.crossing_on = 1'b0;
							end
						end
					end
				end
			end
			default: ;
		endcase
	end

endmodule

`default_nettype wire

FILE: sv/triac_phase_soft_start_unit.sv
// Top level of the triac phase-angle soft-start unit.
//
//  channel  dir  carries                                         beat when
//  item     in   kind, mode, zero_cross                          valid & ready
//  res      out  gate_on, start_done, crossing_enable            valid & ready
//  cfg      in   index (0 start, 1 end, 2 firings/step), data    valid & ready
//
// One beat a cycle while the result is not stalled: an item enters the input
// register; when it moves on, it is applied to the controller state and its
// result lands in the result register in the same cycle. The state update
// sets the rate. arst_n restores configuration, state and valid flags to reset values.
// A stalled result holds the result register; the input register still
// takes a beat whenever it drains. cfg is always ready.
`timescale 1ns / 1ps
`default_nettype none
`include "triac_phase_soft_start_unit_defines.svh"

module triac_phase_soft_start_unit
	import tpss_pkg::*;
(
	input  wire           clk,
	input  wire           arst_n,
	tpss_item_if.sink     item,
	tpss_result_if.source res,
	tpss_cfg_if.sink      cfg
);

	cfg_t  cfg_q;
	st_t   st_q;
	st_t   st_nxt;
	item_t item_s1;
	logic  valid_s1;
	logic  res_valid_q;
	logic  in_acc;
	logic  s1_fire;

	// Handshake control
	assign s1_fire    = valid_s1 && (!res_valid_q || res.ready);
	assign item.ready = !valid_s1 || s1_fire;
	assign in_acc     = item.valid && item.ready;
	assign cfg.ready  = 1'b1;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_delay      <= START_DELAY_RST;
			cfg_q.end_delay        <= END_DELAY_RST;
			cfg_q.firings_per_step <= FIRINGS_PER_STEP_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_START_DELAY:      cfg_q.start_delay      <= cfg.data;
				REG_END_DELAY:        cfg_q.end_delay        <= cfg.data;
				REG_FIRINGS_PER_STEP: cfg_q.firings_per_step <= cfg.data;
				default: ;
			endcase
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else
			valid_s1 <= in_acc || (valid_s1 && !s1_fire);
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			item_s1.kind       <= item.kind;
			item_s1.mode       <= item.mode;
			item_s1.zero_cross <= item.zero_cross;
		end
	end

	// Controller update
	tpss_step u_step (
		.st  (st_q),
		.cfg (cfg_q),
		.itm (item_s1),
		.nxt (st_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			st_q <= ST_RESET;
		else if (s1_fire)
			st_q <= st_nxt;
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_valid_q <= 1'b0;
		else
			res_valid_q <= s1_fire || (res_valid_q && !res.ready);
	end

	always_ff @(posedge clk) begin
		if (s1_fire) begin
			res.gate_on         <= st_nxt.gate_level;
			res.start_done      <= st_nxt.done_flag;
			res.crossing_enable <= st_nxt.crossing_on;
		end
	end

	assign res.valid = res_valid_q;

	// Checks
	`TPSS_ASSERT_NOW(a_cross_not_done, clk, arst_n, st_q.crossing_on, !st_q.done_flag, "crossing enabled while soft start done")
	`TPSS_ASSERT_NOW(a_unarmed_done, clk, arst_n, !st_q.armed_flag, st_q.done_flag, "soft start running while not armed")
	`TPSS_ASSERT_NEXT(a_s1_hold, clk, arst_n, valid_s1 && !s1_fire, valid_s1, "stalled item lost from input register")
	`TPSS_ASSERT_NEXT(a_res_load, clk, arst_n, s1_fire, res_valid_q && !valid_s1 || res_valid_q, "result register not loaded")

endmodule

`default_nettype wire
